// ===== rtl/c8x_pkg.sv =====
// ----------------------------------------------------------------------------
// c8x_pkg
// Shared types and constants for the CHIP-8 instruction execute block.
// ----------------------------------------------------------------------------
`default_nettype none
package c8x_pkg;

  localparam int MEMORY_BYTES = 4096;
  localparam int STACK_DEPTH  = 16;
  localparam int MemAw        = $clog2(MEMORY_BYTES);
  localparam int StackAw      = $clog2(STACK_DEPTH);

  localparam logic [11:0] StartReset = 12'd512;

  localparam logic [1:0] ModeExec  = 2'd0;
  localparam logic [1:0] ModeWrite = 2'd1;
  localparam logic [1:0] ModeRead  = 2'd2;

  // Opcode groups, top nibble of the instruction word.
  localparam logic [3:0] OpcSys    = 4'h0;
  localparam logic [3:0] OpcJump   = 4'h1;
  localparam logic [3:0] OpcCall   = 4'h2;
  localparam logic [3:0] OpcSeImm  = 4'h3;
  localparam logic [3:0] OpcSneImm = 4'h4;
  localparam logic [3:0] OpcSeReg  = 4'h5;
  localparam logic [3:0] OpcLdImm  = 4'h6;
  localparam logic [3:0] OpcAddImm = 4'h7;
  localparam logic [3:0] OpcAlu    = 4'h8;
  localparam logic [3:0] OpcSneReg = 4'h9;
  localparam logic [3:0] OpcLdI    = 4'hA;
  localparam logic [3:0] OpcJumpV0 = 4'hB;
  localparam logic [3:0] OpcRand   = 4'hC;
  localparam logic [3:0] OpcKey    = 4'hE;
  localparam logic [3:0] OpcMisc   = 4'hF;

  localparam logic [15:0] OpcClear  = 16'h00E0;
  localparam logic [15:0] OpcReturn = 16'h00EE;

  localparam logic [3:0] SubMov  = 4'h0;
  localparam logic [3:0] SubOr   = 4'h1;
  localparam logic [3:0] SubAnd  = 4'h2;
  localparam logic [3:0] SubXor  = 4'h3;
  localparam logic [3:0] SubAdd  = 4'h4;
  localparam logic [3:0] SubSub  = 4'h5;
  localparam logic [3:0] SubShr  = 4'h6;
  localparam logic [3:0] SubSubn = 4'h7;
  localparam logic [3:0] SubShl  = 4'hE;

  localparam logic [7:0] KeySkipDown = 8'h9E;
  localparam logic [7:0] KeySkipUp   = 8'hA1;

  localparam logic [7:0] MiscGetDelay = 8'h07;
  localparam logic [7:0] MiscWaitKey  = 8'h0A;
  localparam logic [7:0] MiscSetDelay = 8'h15;
  localparam logic [7:0] MiscSetSound = 8'h18;
  localparam logic [7:0] MiscAddI     = 8'h1E;
  localparam logic [7:0] MiscBcd      = 8'h33;
  localparam logic [7:0] MiscStore    = 8'h55;
  localparam logic [7:0] MiscLoad     = 8'h65;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] opcode;
    logic [15:0] keys_pressed;
    logic [7:0]  random_byte;
    logic [11:0] mem_address;
    logic [7:0]  mem_data;
  } in_word_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic [15:0] index_value;
    logic [7:0]  read_byte;
    logic        clear_screen;
    logic        waiting_key;
    logic [7:0]  delay_value;
    logic [7:0]  sound_value;
  } out_word_t;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StMemRead,
    StMemWait,
    StBcd,
    StMove,
    StDone
  } state_e;

  // Memory request from the sequencer to the memory module.
  typedef struct packed {
    logic             we;
    logic             re;
    logic [MemAw-1:0] addr;
    logic [7:0]       wdata;
  } mem_req_t;

endpackage
`default_nettype wire

// ===== rtl/chip8_instruction_execute.sv =====
// ----------------------------------------------------------------------------
// chip8_instruction_execute
// Executes CHIP-8 opcodes, memory writes and memory reads, one word at a time.
// ----------------------------------------------------------------------------
// A word is taken only while the block is idle. Most opcodes, memory writes and
// the unused mode finish in the execute state; memory reads add a wait state,
// and Fx33, Fx55 and Fx65 are paced by the single port of the main memory,
// through which every byte passes in turn; an Fx65 byte is read, then captured.
// The result waits in the output register until taken, and the block returns to
// its idle state before the next word.
`default_nettype none
module chip8_instruction_execute (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [11:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire c8x_pkg::in_word_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output c8x_pkg::out_word_t      out_data_o
);
  import c8x_pkg::*;

  state_e state_q, state_d;
  in_word_t w_q;
  logic [7:0]  v_q [16];
  logic [11:0] pc_q;
  logic [15:0] i_q;
  logic [11:0] stk_q [STACK_DEPTH];
  logic [StackAw-1:0] sp_q;
  logic [7:0]  dt_q, st_q;
  logic [3:0]  cnt_q;
  logic        rd_ph_q;
  logic [7:0]  bcd_q;
  logic        clr_q, wait_q;
  logic [7:0]  rdb_q;
  mem_req_t    req;
  logic [7:0]  mrd;

  logic [3:0] x, y, lo;
  logic [7:0] kk, vx, vy;
  logic [8:0] sum;
  logic       keyhit;
  logic [3:0] firstkey;
  logic       anykey;
  logic       skip;

  logic [15:0] bcd_prod;
  logic [3:0]  bcd_tens;
  logic [7:0]  bcd_dig, bcd_rem;

  assign x  = w_q.opcode[11:8];
  assign y  = w_q.opcode[7:4];
  assign lo = w_q.opcode[3:0];
  assign kk = w_q.opcode[7:0];
  assign vx = v_q[x];
  assign vy = v_q[y];
  assign sum = {1'b0, vx} + {1'b0, vy};
  assign keyhit = w_q.keys_pressed[vx[3:0]];
  assign anykey = |w_q.keys_pressed;

  always_comb begin
    firstkey = 4'd0;
    for (int k = 15; k >= 0; k--) if (w_q.keys_pressed[k]) firstkey = 4'(k);
  end

  always_comb begin
    unique case (w_q.opcode[15:12])
      OpcSeImm: skip = (vx == kk);
      OpcSneImm: skip = (vx != kk);
      OpcSeReg: skip = (lo == 4'd0) && (vx == vy);
      OpcSneReg: skip = (lo == 4'd0) && (vx != vy);
      OpcKey: skip = (kk == KeySkipDown && keyhit) || (kk == KeySkipUp && !keyhit);
      default: skip = 1'b0;
    endcase
  end

  // Digit split: hundreds by compare and subtract, tens by reciprocal multiply.
  assign bcd_prod = {8'd0, bcd_q} * 16'd205;

  always_comb begin
    bcd_tens = bcd_prod[14:11];
    unique case (cnt_q)
      4'd0: begin
        priority if (bcd_q >= 8'd200) begin
          bcd_dig = 8'd2;
          bcd_rem = bcd_q - 8'd200;
        end else if (bcd_q >= 8'd100) begin
          bcd_dig = 8'd1;
          bcd_rem = bcd_q - 8'd100;
        end else begin
          bcd_dig = 8'd0;
          bcd_rem = bcd_q;
        end
      end
      4'd1: begin
        bcd_dig = {4'd0, bcd_tens};
        bcd_rem = bcd_q - ({1'b0, bcd_tens, 3'd0} + {3'd0, bcd_tens, 1'b0});
      end
      default: begin
        bcd_dig = bcd_q;
        bcd_rem = bcd_q;
      end
    endcase
  end

  assign cfg_ready_o = (state_q == StIdle);
  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StDone);

  always_comb begin
    out_data_o.program_counter = pc_q;
    out_data_o.index_value     = i_q;
    out_data_o.read_byte       = rdb_q;
    out_data_o.clear_screen    = clr_q;
    out_data_o.waiting_key     = wait_q;
    out_data_o.delay_value     = dt_q;
    out_data_o.sound_value     = st_q;
  end

  logic is_f;
  assign is_f = (w_q.opcode[15:12] == OpcMisc);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = StExec;
      StExec: begin
        if (w_q.mode == ModeRead) state_d = StMemWait;
        else if (w_q.mode == ModeExec && is_f && kk == MiscBcd) state_d = StBcd;
        else if (w_q.mode == ModeExec && is_f && (kk == MiscStore || kk == MiscLoad))
          state_d = StMove;
        else state_d = StDone;
      end
      StMemWait: state_d = StDone;
      StMemRead: state_d = StDone;
      StBcd: if (cnt_q == 4'd2) state_d = StDone;
      StMove: if (cnt_q == x && (kk == MiscStore || rd_ph_q)) state_d = StDone;
      StDone: if (!out_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  logic [15:0] maddr16;
  assign maddr16 = i_q + {12'd0, cnt_q};

  always_comb begin
    req = '0;
    unique case (state_q)
      StExec: begin
        req.addr  = w_q.mem_address[MemAw-1:0];
        req.wdata = w_q.mem_data;
        req.we    = (w_q.mode == ModeWrite);
        req.re    = (w_q.mode == ModeRead);
      end
      StBcd: begin
        req.we    = 1'b1;
        req.addr  = maddr16[MemAw-1:0];
        req.wdata = bcd_dig;
      end
      StMove: begin
        req.addr  = maddr16[MemAw-1:0];
        req.wdata = v_q[cnt_q];
        req.we    = (kk == MiscStore);
        req.re    = (kk == MiscLoad) && !rd_ph_q;
      end
      default: req = '0;
    endcase
  end

  c8x_mem u_mem (.clk_i(clk_i), .req_i(req), .rdata_o(mrd));

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) w_q <= in_data_i;
    if (state_q == StMemWait) rdb_q <= mrd;
    else if (state_q == StExec) rdb_q <= 8'd0;
    if (state_q == StExec) bcd_q <= vx;
    else if (state_q == StBcd) bcd_q <= bcd_rem;
    if (state_q == StExec && w_q.mode == ModeExec && w_q.opcode[15:12] == OpcCall)
      stk_q[sp_q] <= pc_q + 12'd2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      for (int k = 0; k < 16; k++) v_q[k] <= 8'd0;
      pc_q <= StartReset;
      i_q <= 16'd0;
      sp_q <= '0;
      dt_q <= 8'd0;
      st_q <= 8'd0;
      cnt_q <= 4'd0;
      rd_ph_q <= 1'b0;
      clr_q <= 1'b0;
      wait_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) pc_q <= cfg_data_i;
      if (state_q == StExec) begin
        cnt_q   <= 4'd0;
        rd_ph_q <= 1'b0;
        clr_q   <= 1'b0;
        wait_q  <= 1'b0;
        if (w_q.mode == ModeExec) begin
          pc_q <= skip ? pc_q + 12'd4 : pc_q + 12'd2;
          unique case (w_q.opcode[15:12])
            OpcSys: begin
              if (w_q.opcode == OpcClear) clr_q <= 1'b1;
              else if (w_q.opcode == OpcReturn) begin
                pc_q <= stk_q[sp_q - 1'b1];
                sp_q <= sp_q - 1'b1;
              end
            end
            OpcJump: pc_q <= w_q.opcode[11:0];
            OpcCall: begin
              pc_q <= w_q.opcode[11:0];
              sp_q <= sp_q + 1'b1;
            end
            OpcLdImm: v_q[x] <= kk;
            OpcAddImm: v_q[x] <= vx + kk;
            OpcAlu: begin
              unique case (lo)
                SubMov: v_q[x] <= vy;
                SubOr: v_q[x] <= vx | vy;
                SubAnd: v_q[x] <= vx & vy;
                SubXor: v_q[x] <= vx ^ vy;
                SubAdd: begin
                  v_q[15] <= {7'd0, sum[8]};
                  v_q[x]  <= sum[7:0];
                end
                SubSub: begin
                  v_q[15] <= {7'd0, vx > vy};
                  v_q[x]  <= vx - vy;
                end
                SubShr: begin
                  v_q[15] <= {7'd0, vx[0]};
                  v_q[x]  <= vx >> 1;
                end
                SubSubn: begin
                  v_q[15] <= {7'd0, vy > vx};
                  v_q[x]  <= vy - vx;
                end
                SubShl: begin
                  v_q[15] <= {7'd0, vx[7]};
                  v_q[x]  <= vx << 1;
                end
                default: ;
              endcase
            end
            OpcLdI: i_q <= {4'd0, w_q.opcode[11:0]};
            OpcJumpV0: pc_q <= w_q.opcode[11:0] + {4'd0, v_q[0]};
            OpcRand: v_q[x] <= w_q.random_byte & kk;
            OpcMisc: begin
              unique case (kk)
                MiscGetDelay: v_q[x] <= dt_q;
                MiscWaitKey: begin
                  if (anykey) v_q[x] <= {4'd0, firstkey};
                  else begin
                    pc_q   <= pc_q;
                    wait_q <= 1'b1;
                  end
                end
                MiscSetDelay: dt_q <= vx;
                MiscSetSound: st_q <= vx;
                MiscAddI: i_q <= i_q + {8'd0, vx};
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
      if (state_q == StBcd) cnt_q <= cnt_q + 4'd1;
      if (state_q == StMove) begin
        if (kk == MiscStore) begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == x) i_q <= i_q + {12'd0, x} + 16'd1;
        end else if (!rd_ph_q) rd_ph_q <= 1'b1;
        else begin
          v_q[cnt_q] <= mrd;
          rd_ph_q    <= 1'b0;
          cnt_q      <= cnt_q + 4'd1;
          if (cnt_q == x) i_q <= i_q + {12'd0, x} + 16'd1;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o) else $error("accept while busy");
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result dropped");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !out_valid_o) else $error("cfg ready while result pending");
`endif
endmodule
`default_nettype wire

// ===== rtl/c8x_mem.sv =====
// ----------------------------------------------------------------------------
// c8x_mem
// Main byte memory, one port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module c8x_mem (
  input  wire logic              clk_i,
  input  wire c8x_pkg::mem_req_t req_i,
  output logic [7:0]             rdata_o
);
  import c8x_pkg::*;

  logic [7:0] mem_q [MEMORY_BYTES];

  always_ff @(posedge clk_i) begin
    if (req_i.we) mem_q[req_i.addr] <= req_i.wdata;
    if (req_i.re) rdata_o <= mem_q[req_i.addr];
  end
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CHIP-8 execute block testbench
// Sends opcodes, memory writes and memory reads through the input channel and
// checks every result word against an in-bench model of the register file,
// PC, I, stack, timers and memory. Directed opcodes first, then start address
// changes and a long random run with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb;
  import c8x_pkg::*;

  localparam int Limit   = 600000;
  localparam int Settle  = 40;

  typedef enum logic [3:0] {
    ClsSys, ClsJump, ClsCall, ClsSeImm, ClsSneImm, ClsSeReg, ClsLdImm, ClsAddImm,
    ClsAlu, ClsSneReg, ClsLdI, ClsJumpV0, ClsRand, ClsDraw, ClsKey, ClsMisc
  } op_class_e;

  localparam logic [15:0] OpClear  = 16'h00E0;
  localparam logic [15:0] OpReturn = 16'h00EE;
  localparam logic [3:0] AluMov = 4'h0, AluOr = 4'h1, AluAnd = 4'h2, AluXor = 4'h3,
                         AluAdd = 4'h4, AluSub = 4'h5, AluShr = 4'h6, AluSubn = 4'h7,
                         AluShl = 4'hE;
  localparam logic [7:0] KeyDown = 8'h9E, KeyUp = 8'hA1;
  localparam logic [7:0] FGetDelay = 8'h07, FWaitKey = 8'h0A, FSetDelay = 8'h15,
                         FSetSound = 8'h18, FAddI = 8'h1E, FBcd = 8'h33,
                         FStore = 8'h55, FLoad = 8'h65;
  localparam logic [1:0] ModeNone = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [11:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_word_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_word_t out_data_o;

  chip8_instruction_execute DUT (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_data_i, .out_valid_o, .out_stall_i, .out_data_o
  );

  always #10 clk_i = ~clk_i;

  // model state
  logic [7:0]  vreg [16];
  logic [11:0] pc_m;
  logic [15:0] idx_m;
  logic [11:0] stack_m [16];
  bit          stack_set [16];
  logic [3:0]  sp_m;
  logic [7:0]  delay_m, sound_m;
  logic [7:0]  mem_m [4096];
  bit          mem_set [4096];

  out_word_t results_due [$];
  int errs = 0;
  int cycles = 0;
  bit quiet = 1'b0;

  function automatic out_word_t run_word(in_word_t w);
    out_word_t r;
    logic [15:0] op;
    logic [3:0] x, y;
    logic [7:0] kk, vx, vy;
    logic [8:0] sum;
    logic [15:0] a;
    int k;
    bit found;
    r = '0;
    op = w.opcode;
    x = op[11:8];
    y = op[7:4];
    kk = op[7:0];
    vx = vreg[x];
    vy = vreg[y];
    if (w.mode == ModeWrite) begin
      mem_m[w.mem_address] = w.mem_data;
      mem_set[w.mem_address] = 1'b1;
    end else if (w.mode == ModeRead) begin
      r.read_byte = mem_m[w.mem_address];
    end else if (w.mode == ModeExec) begin
      pc_m = pc_m + 12'd2;
      case (op_class_e'(op[15:12]))
        ClsSys: begin
          if (op == OpClear) r.clear_screen = 1'b1;
          else if (op == OpReturn) begin
            sp_m = sp_m - 4'd1;
            pc_m = stack_m[sp_m];
          end
        end
        ClsJump: pc_m = op[11:0];
        ClsCall: begin
          stack_m[sp_m] = pc_m;
          stack_set[sp_m] = 1'b1;
          sp_m = sp_m + 4'd1;
          pc_m = op[11:0];
        end
        ClsSeImm: if (vx == kk) pc_m = pc_m + 12'd2;
        ClsSneImm: if (vx != kk) pc_m = pc_m + 12'd2;
        ClsSeReg: if (op[3:0] == 4'h0 && vx == vy) pc_m = pc_m + 12'd2;
        ClsLdImm: vreg[x] = kk;
        ClsAddImm: vreg[x] = vx + kk;
        ClsAlu: begin
          case (op[3:0])
            AluMov: vreg[x] = vy;
            AluOr:  vreg[x] = vx | vy;
            AluAnd: vreg[x] = vx & vy;
            AluXor: vreg[x] = vx ^ vy;
            AluAdd: begin
              sum = {1'b0, vx} + {1'b0, vy};
              vreg[15] = {7'd0, sum[8]};
              vreg[x] = sum[7:0];
            end
            AluSub: begin
              vreg[15] = {7'd0, vx > vy};
              vreg[x] = vx - vy;
            end
            AluShr: begin
              vreg[15] = {7'd0, vx[0]};
              vreg[x] = vx >> 1;
            end
            AluSubn: begin
              vreg[15] = {7'd0, vy > vx};
              vreg[x] = vy - vx;
            end
            AluShl: begin
              vreg[15] = {7'd0, vx[7]};
              vreg[x] = vx << 1;
            end
            default: ;
          endcase
        end
        ClsSneReg: if (op[3:0] == 4'h0 && vx != vy) pc_m = pc_m + 12'd2;
        ClsLdI: idx_m = {4'd0, op[11:0]};
        ClsJumpV0: pc_m = op[11:0] + {4'd0, vreg[0]};
        ClsRand: vreg[x] = w.random_byte & kk;
        ClsKey: begin
          if (kk == KeyDown && w.keys_pressed[vx[3:0]]) pc_m = pc_m + 12'd2;
          else if (kk == KeyUp && !w.keys_pressed[vx[3:0]]) pc_m = pc_m + 12'd2;
        end
        ClsMisc: begin
          case (kk)
            FGetDelay: vreg[x] = delay_m;
            FWaitKey: begin
              found = 1'b0;
              for (k = 15; k >= 0; k--)
                if (w.keys_pressed[k]) begin
                  found = 1'b1;
                  vreg[x] = 8'(k);
                end
              if (!found) begin
                pc_m = pc_m - 12'd2;
                r.waiting_key = 1'b1;
              end
            end
            FSetDelay: delay_m = vx;
            FSetSound: sound_m = vx;
            FAddI: idx_m = idx_m + {8'd0, vx};
            FBcd: begin
              for (k = 0; k < 3; k++) begin
                a = idx_m + 16'(k);
                mem_set[a[11:0]] = 1'b1;
              end
              a = idx_m;
              mem_m[a[11:0]] = vx / 8'd100;
              a = idx_m + 16'd1;
              mem_m[a[11:0]] = (vx / 8'd10) % 8'd10;
              a = idx_m + 16'd2;
              mem_m[a[11:0]] = vx % 8'd10;
            end
            FStore: begin
              for (k = 0; k <= x; k++) begin
                a = idx_m + 16'(k);
                mem_m[a[11:0]] = vreg[k];
                mem_set[a[11:0]] = 1'b1;
              end
              idx_m = idx_m + {12'd0, x} + 16'd1;
            end
            FLoad: begin
              for (k = 0; k <= x; k++) begin
                a = idx_m + 16'(k);
                vreg[k] = mem_m[a[11:0]];
              end
              idx_m = idx_m + {12'd0, x} + 16'd1;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    r.program_counter = pc_m;
    r.index_value = idx_m;
    r.delay_value = delay_m;
    r.sound_value = sound_m;
    return r;
  endfunction

  task automatic push_word(in_word_t w);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    results_due.push_back(run_word(w));
  endtask

  function automatic in_word_t mem_op(logic [1:0] m, logic [11:0] adr);
    in_word_t w;
    w = '0;
    w.mode = m;
    w.mem_address = adr;
    w.mem_data = 8'($urandom_range(255));
    return w;
  endfunction

  // first write any byte or stack entry the word would read unwritten
  task automatic issue(in_word_t w);
    logic [15:0] a;
    in_word_t c;
    int k;
    if (w.mode == ModeRead && !mem_set[w.mem_address])
      push_word(mem_op(ModeWrite, w.mem_address));
    if (w.mode == ModeExec && w.opcode == OpReturn && !stack_set[sp_m - 4'd1]) begin
      c = w;
      c.opcode = {ClsCall, 12'($urandom_range(4095))};
      push_word(c);
    end
    if (w.mode == ModeExec && w.opcode[15:12] == ClsMisc && w.opcode[7:0] == FLoad)
      for (k = 0; k <= w.opcode[11:8]; k++) begin
        a = idx_m + 16'(k);
        if (!mem_set[a[11:0]]) push_word(mem_op(ModeWrite, a[11:0]));
      end
    push_word(w);
  endtask

  task automatic exec_op(logic [15:0] op, logic [15:0] keys = '0, logic [7:0] rnd = '0);
    in_word_t w;
    w = '0;
    w.mode = ModeExec;
    w.opcode = op;
    w.keys_pressed = keys;
    w.random_byte = rnd;
    w.mem_address = 12'($urandom_range(4095));
    w.mem_data = 8'($urandom_range(255));
    issue(w);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic set_start(logic [11:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    pc_m = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic in_word_t random_word();
    in_word_t w;
    logic [3:0] x;
    int p;
    w.mode = ModeExec;
    w.opcode = 16'($urandom_range(65535));
    w.keys_pressed = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(65535));
    w.random_byte = 8'($urandom_range(255));
    w.mem_address = 12'($urandom_range(4095));
    w.mem_data = 8'($urandom_range(255));
    x = w.opcode[11:8];
    p = $urandom_range(99);
    if (p < 10) w.mode = ModeWrite;
    else if (p < 18) w.mode = ModeRead;
    else if (p < 20) w.mode = ModeNone;
    p = $urandom_range(9);
    case (op_class_e'(w.opcode[15:12]))
      ClsSys: if (p < 4) w.opcode = OpClear; else if (p < 8) w.opcode = OpReturn;
      ClsSeImm, ClsSneImm: if (p < 5) w.opcode[7:0] = vreg[x];
      ClsSeReg, ClsSneReg: begin
        if (p < 8) w.opcode[3:0] = 4'h0;
        if (p < 3) w.opcode[7:4] = x;
      end
      ClsAlu: if (p < 9) w.opcode[3:0] = (p < 8) ? 4'($urandom_range(7)) : AluShl;
      ClsKey: if (p < 9) w.opcode[7:0] = (p < 5) ? KeyDown : KeyUp;
      ClsMisc: if (p < 9) begin
        case ($urandom_range(7))
          0: w.opcode[7:0] = FGetDelay;
          1: w.opcode[7:0] = FWaitKey;
          2: w.opcode[7:0] = FSetDelay;
          3: w.opcode[7:0] = FSetSound;
          4: w.opcode[7:0] = FAddI;
          5: w.opcode[7:0] = FBcd;
          6: w.opcode[7:0] = FStore;
          default: w.opcode[7:0] = FLoad;
        endcase
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic test_directed();
    exec_op(OpClear);
    exec_op({ClsLdImm, 4'h1, 8'hFF});
    exec_op({ClsAddImm, 4'h1, 8'h02});
    exec_op({ClsLdImm, 4'h2, 8'hF3});
    exec_op({ClsAlu, 4'hF, 4'h2, AluAdd});
    exec_op({ClsAlu, 4'h3, 4'h2, AluSub});
    exec_op({ClsAlu, 4'h4, 4'h2, AluSubn});
    exec_op({ClsAlu, 4'h2, 4'h1, AluShr});
    exec_op({ClsAlu, 4'h2, 4'h1, AluShl});
    exec_op({ClsAlu, 4'h5, 4'h2, 4'hF});
    exec_op({ClsSeImm, 4'h1, 8'h01});
    exec_op({ClsSeReg, 4'h5, 4'h6, 4'h0});
    exec_op({ClsSneReg, 4'h1, 4'h2, 4'h0});
    exec_op({ClsKey, 4'h2, KeyDown}, 16'h8000);
    exec_op({ClsKey, 4'h2, KeyUp}, 16'hFFFF);
    exec_op({ClsMisc, 4'h7, FWaitKey}, 16'h0000);
    exec_op({ClsMisc, 4'h7, FWaitKey}, 16'hA050);
    exec_op({ClsRand, 4'h8, 8'hFF}, '0, 8'hA5);
    exec_op({ClsMisc, 4'h2, FSetDelay});
    exec_op({ClsMisc, 4'h8, FSetSound});
    exec_op({ClsMisc, 4'h9, FGetDelay});
    exec_op({ClsLdI, 12'hFFE});
    exec_op({ClsMisc, 4'hF, FStore});
    exec_op({ClsMisc, 4'h2, FBcd});
    exec_op({ClsLdI, 12'hFFE});
    exec_op({ClsMisc, 4'hF, FLoad});
    exec_op({ClsMisc, 4'h1, FAddI});
    exec_op({ClsCall, 12'hFFF});
    exec_op(OpReturn);
    exec_op({ClsJumpV0, 12'hFFF});
    exec_op({ClsJump, 12'h000});
    exec_op({ClsDraw, 12'h123});
    exec_op(16'h0123);
    issue(mem_op(ModeRead, 12'hFFF));
    issue(mem_op(ModeNone, 12'h000));
  endtask

  task automatic test_start_address();
    logic [11:0] vals [4];
    int k, n;
    vals = '{12'h000, 12'hFFF, 12'($urandom_range(4095)), StartReset};
    for (k = 0; k < 4; k++) begin
      set_start(vals[k]);
      for (n = 0; n < 12; n++) issue(random_word());
      drain();
    end
  endtask

  task automatic test_random();
    int n;
    for (n = 0; n < 700; n++) begin
      quiet = (n >= 300 && n < 420);
      issue(random_word());
    end
    quiet = 1'b0;
  endtask

  always @(negedge clk_i)
    out_stall_i <= !quiet && ($urandom_range(99) < 10);

  always @(posedge clk_i) begin
    out_word_t e;
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (results_due.size() == 0) begin
        $error("result word with nothing expected");
        errs++;
      end else begin
        e = results_due.pop_front();
        if (out_data_o.program_counter !== e.program_counter) begin
          $error("program_counter exp %h got %h", e.program_counter,
                 out_data_o.program_counter);
          errs++;
        end
        if (out_data_o.index_value !== e.index_value) begin
          $error("index_value exp %h got %h", e.index_value, out_data_o.index_value);
          errs++;
        end
        if (out_data_o.read_byte !== e.read_byte) begin
          $error("read_byte exp %h got %h", e.read_byte, out_data_o.read_byte);
          errs++;
        end
        if (out_data_o.clear_screen !== e.clear_screen) begin
          $error("clear_screen exp %b got %b", e.clear_screen, out_data_o.clear_screen);
          errs++;
        end
        if (out_data_o.waiting_key !== e.waiting_key) begin
          $error("waiting_key exp %b got %b", e.waiting_key, out_data_o.waiting_key);
          errs++;
        end
        if (out_data_o.delay_value !== e.delay_value) begin
          $error("delay_value exp %h got %h", e.delay_value, out_data_o.delay_value);
          errs++;
        end
        if (out_data_o.sound_value !== e.sound_value) begin
          $error("sound_value exp %h got %h", e.sound_value, out_data_o.sound_value);
          errs++;
        end
      end
    end
  end

  initial begin
    for (int k = 0; k < 16; k++) begin
      vreg[k] = '0;
      stack_m[k] = '0;
      stack_set[k] = 1'b0;
    end
    for (int k = 0; k < 4096; k++) begin
      mem_m[k] = '0;
      mem_set[k] = 1'b0;
    end
    pc_m = StartReset;
    idx_m = '0;
    sp_m = '0;
    delay_m = '0;
    sound_m = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    drain();
    test_start_address();
    test_random();
    drain();
    if (errs == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== chip8_instruction_execute.f =====
rtl/c8x_pkg.sv
rtl/c8x_mem.sv
rtl/chip8_instruction_execute.sv
tb/tb.sv
